### sv/scs_pkg.sv
// Package: request codes, status codes and fixed field widths for the coordinate stack.
`default_nettype none
package scs_pkg;
    localparam int REQ_W = 4;
    localparam int ST_W  = 2;
    localparam int IDX_W = 8;

    localparam logic [REQ_W-1:0] REQ_PUSH     = 4'd0;
    localparam logic [REQ_W-1:0] REQ_POP      = 4'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 4'd2;
    localparam logic [REQ_W-1:0] REQ_NEXT     = 4'd3;
    localparam logic [REQ_W-1:0] REQ_REWIND   = 4'd4;
    localparam logic [REQ_W-1:0] REQ_CONTAINS = 4'd5;
    localparam logic [REQ_W-1:0] REQ_SETMARK  = 4'd6;
    localparam logic [REQ_W-1:0] REQ_SORT     = 4'd7;
    localparam logic [REQ_W-1:0] REQ_MARKAT   = 4'd8;
    localparam logic [REQ_W-1:0] REQ_TOP      = 4'd9;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;
endpackage
`default_nettype wire

### sv/scs_req_if.sv
// Interface: request channel of the coordinate stack.
`default_nettype none
interface scs_req_if #(
    parameter int COORD_BITS = 8,
    parameter int MARK_BITS  = 16
);
    logic                          valid;
    logic                          ready;
    logic [scs_pkg::REQ_W-1:0]     req_type;
    logic [COORD_BITS-1:0]         x_coord;
    logic [COORD_BITS-1:0]         y_coord;
    logic signed [MARK_BITS-1:0]   mark_value;
    logic [scs_pkg::IDX_W-1:0]     entry_index;

    modport source (output valid, req_type, x_coord, y_coord, mark_value, entry_index,
                    input ready);
    modport sink (input valid, req_type, x_coord, y_coord, mark_value, entry_index,
                  output ready);
endinterface
`default_nettype wire

### sv/scs_rsp_if.sv
// Interface: result channel of the coordinate stack.
`default_nettype none
interface scs_rsp_if #(
    parameter int COORD_BITS = 8,
    parameter int MARK_BITS  = 16,
    parameter int LEN_BITS   = 7
);
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [COORD_BITS-1:0]       x_out;
    logic [COORD_BITS-1:0]       y_out;
    logic signed [MARK_BITS-1:0] mark_out;
    logic                        more_after;
    logic [LEN_BITS-1:0]         length;
    logic [scs_pkg::ST_W-1:0]    status;

    modport source (output valid, hit, x_out, y_out, mark_out, more_after, length, status,
                    input ready);
    modport sink (input valid, hit, x_out, y_out, mark_out, more_after, length, status,
                  output ready);
endinterface
`default_nettype wire

### sv/scs_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module scs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

### sv/scored_coordinate_stack_core.sv
// Top level: bounded LIFO of scored coordinates with search, sort and cursor.
//
//  channel | dir | modport | payload
//  i_req   | in  | sink    | req_type, x_coord, y_coord, mark_value, entry_index
//  o_rsp   | out | source  | hit, x_out, y_out, mark_out, more_after, length, status
//
// One request at a time. Push, clear, rewind and error cases finish without a RAM read;
// pop, top, next, setmark and markat do one RAM read. Contains reads each entry scanned
// in turn, and sort runs an exchange sort over all n entries through the single RAM port.
// Reset is synchronous; entry storage is not cleared, only the count, cursor, state and output valid.
// A finished result waits in an output register while the next request is taken.
`default_nettype none
module scored_coordinate_stack_core #(
    parameter int DEPTH      = 64,
    parameter int COORD_BITS = 8,
    parameter int MARK_BITS  = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    scs_req_if.sink  i_req,
    scs_rsp_if.source o_rsp
);
    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int DW   = 2 * COORD_BITS + MARK_BITS;
    localparam int CMPW = (CW > scs_pkg::IDX_W) ? CW : scs_pkg::IDX_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_SRCH_RD, S_SRCH_CMP, S_SORT_RDA, S_SORT_LDA,
        S_SORT_RDB, S_SORT_CMP, S_SORT_WRA, S_DONE
    } t_state;

    t_state                     r_state;
    logic [CW-1:0]              r_count;
    logic [PW-1:0]              r_pos;
    logic                       r_started;
    logic [scs_pkg::REQ_W-1:0]  r_req;
    logic [COORD_BITS-1:0]      r_x, r_y;
    logic [MARK_BITS-1:0]       r_mv;
    logic [PW-1:0]              r_addr;
    logic [CW-1:0]              r_i, r_j;
    logic [DW-1:0]              r_a;
    // staged result
    logic                       r_s_hit, r_s_more;
    logic [COORD_BITS-1:0]      r_s_x, r_s_y;
    logic [MARK_BITS-1:0]       r_s_mark;
    logic [scs_pkg::ST_W-1:0]   r_s_st;
    // output register
    logic                       r_ovld, r_o_hit, r_o_more;
    logic [COORD_BITS-1:0]      r_o_x, r_o_y;
    logic [MARK_BITS-1:0]       r_o_mark;
    logic [CW-1:0]              r_o_len;
    logic [scs_pkg::ST_W-1:0]   r_o_st;

    logic                       mem_we;
    logic [PW-1:0]              mem_addr;
    logic [DW-1:0]              mem_wdata, mem_rdata;

    logic                       w_acc, w_next_ok, w_swap, w_out_free;
    logic [CW-1:0]              w_npos, w_pos_c;
    logic [CMPW-1:0]            w_idx_c, w_cnt_c;

    function automatic logic [PW-1:0] slot_of(input logic [CW-1:0] cnt,
                                              input logic [CW-1:0] pos);
        logic [CW-1:0] s;
        s = cnt - 1'b1 - pos;
        return s[PW-1:0];
    endfunction

    scs_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_out_free  = !r_ovld || o_rsp.ready;

    // cursor step for next
    assign w_pos_c   = CW'(r_pos);
    assign w_npos    = r_started ? w_pos_c + 1'b1 : w_pos_c;
    assign w_next_ok = (r_count != '0) && !(r_started && (w_pos_c + 1'b1 >= r_count));
    assign w_idx_c   = CMPW'(i_req.entry_index);
    assign w_cnt_c   = CMPW'(r_count);
    assign w_swap    = $signed(r_a[MARK_BITS-1:0]) < $signed(mem_rdata[MARK_BITS-1:0]);

    // RAM port control
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_addr;
        mem_wdata = r_a;
        case (r_state)
            S_IDLE: begin
                case (i_req.req_type)
                    scs_pkg::REQ_PUSH: begin
                        mem_we    = w_acc && (r_count < CW'(DEPTH));
                        mem_addr  = r_count[PW-1:0];
                        mem_wdata = {i_req.x_coord, i_req.y_coord, {MARK_BITS{1'b0}}};
                    end
                    scs_pkg::REQ_POP, scs_pkg::REQ_TOP: mem_addr = slot_of(r_count, '0);
                    scs_pkg::REQ_NEXT:    mem_addr = slot_of(r_count, w_npos);
                    scs_pkg::REQ_SETMARK: mem_addr = slot_of(r_count, w_pos_c);
                    scs_pkg::REQ_MARKAT: begin
                        mem_addr = PW'(w_cnt_c - 1'b1 - w_idx_c);
                    end
                    default: mem_addr = r_addr;
                endcase
            end
            S_RD: begin
                mem_we    = (r_req == scs_pkg::REQ_SETMARK);
                mem_wdata = {mem_rdata[DW-1:MARK_BITS], r_mv};
            end
            S_SRCH_RD:  mem_addr = r_i[PW-1:0];
            S_SORT_RDA: mem_addr = slot_of(r_count, r_i);
            S_SORT_RDB: mem_addr = slot_of(r_count, r_j);
            S_SORT_CMP: begin
                mem_we   = w_swap;
                mem_addr = slot_of(r_count, r_j);
            end
            S_SORT_WRA: begin
                mem_we   = 1'b1;
                mem_addr = slot_of(r_count, r_i);
            end
            default: mem_addr = r_addr;
        endcase
    end

    // sequencer, state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pos     <= '0;
            r_started <= 1'b0;
            r_ovld    <= 1'b0;
        end else begin
            if (r_ovld && o_rsp.ready && r_state != S_DONE) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_req    <= i_req.req_type;
                        r_x      <= i_req.x_coord;
                        r_y      <= i_req.y_coord;
                        r_mv     <= i_req.mark_value;
                        r_addr   <= mem_addr;
                        r_s_hit  <= 1'b0;
                        r_s_more <= 1'b0;
                        r_s_x    <= '0;
                        r_s_y    <= '0;
                        r_s_mark <= '0;
                        r_s_st   <= scs_pkg::ST_OK;
                        r_state  <= S_DONE;
                        case (i_req.req_type)
                            scs_pkg::REQ_PUSH: begin
                                if (r_count < CW'(DEPTH)) begin
                                    r_count   <= r_count + 1'b1;
                                    r_pos     <= '0;
                                    r_started <= 1'b0;
                                end else begin
                                    r_s_st <= scs_pkg::ST_FULL;
                                end
                            end
                            scs_pkg::REQ_POP: begin
                                if (r_count == '0) begin
                                    r_s_st <= scs_pkg::ST_EMPTY;
                                end else begin
                                    r_count   <= r_count - 1'b1;
                                    r_pos     <= '0;
                                    r_started <= 1'b0;
                                    r_state   <= S_RD;
                                end
                            end
                            scs_pkg::REQ_CLEAR: begin
                                r_count   <= '0;
                                r_pos     <= '0;
                                r_started <= 1'b0;
                            end
                            scs_pkg::REQ_NEXT: begin
                                if (r_count == '0) begin
                                    r_s_st <= scs_pkg::ST_EMPTY;
                                end else if (!w_next_ok) begin
                                    r_s_st <= scs_pkg::ST_RANGE;
                                end else begin
                                    r_pos     <= w_npos[PW-1:0];
                                    r_started <= 1'b1;
                                    r_state   <= S_RD;
                                end
                            end
                            scs_pkg::REQ_REWIND: begin
                                r_pos     <= '0;
                                r_started <= 1'b0;
                            end
                            scs_pkg::REQ_CONTAINS: begin
                                r_i     <= '0;
                                r_state <= S_SRCH_RD;
                            end
                            scs_pkg::REQ_SETMARK: begin
                                if (r_count == '0) begin
                                    r_s_st <= scs_pkg::ST_EMPTY;
                                end else if (w_pos_c >= r_count) begin
                                    r_s_st <= scs_pkg::ST_RANGE;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            scs_pkg::REQ_SORT: begin
                                r_pos     <= '0;
                                r_started <= 1'b0;
                                r_i       <= '0;
                                if (r_count >= CW'(2)) begin
                                    r_state <= S_SORT_RDA;
                                end
                            end
                            scs_pkg::REQ_MARKAT: begin
                                r_pos <= '0;
                                if (w_idx_c >= w_cnt_c) begin
                                    r_s_st   <= scs_pkg::ST_RANGE;
                                    r_s_mark <= '1;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            scs_pkg::REQ_TOP: begin
                                if (r_count == '0) begin
                                    r_s_st <= scs_pkg::ST_EMPTY;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            default: r_s_st <= scs_pkg::ST_OK;
                        endcase
                    end
                end
                // read data back for single-entry requests
                S_RD: begin
                    r_s_hit <= 1'b1;
                    r_state <= S_DONE;
                    case (r_req)
                        scs_pkg::REQ_MARKAT: r_s_mark <= mem_rdata[MARK_BITS-1:0];
                        scs_pkg::REQ_NEXT, scs_pkg::REQ_SETMARK: begin
                            r_s_x    <= mem_rdata[DW-1 -: COORD_BITS];
                            r_s_y    <= mem_rdata[MARK_BITS +: COORD_BITS];
                            r_s_mark <= (r_req == scs_pkg::REQ_SETMARK) ? r_mv
                                                                        : mem_rdata[MARK_BITS-1:0];
                            r_s_more <= (w_pos_c + 1'b1 < r_count);
                        end
                        default: begin
                            r_s_x <= mem_rdata[DW-1 -: COORD_BITS];
                            r_s_y <= mem_rdata[MARK_BITS +: COORD_BITS];
                        end
                    endcase
                end
                // linear search over slots
                S_SRCH_RD: begin
                    r_state <= (r_i < r_count) ? S_SRCH_CMP : S_DONE;
                end
                S_SRCH_CMP: begin
                    if (mem_rdata[DW-1 -: COORD_BITS] == r_x &&
                        mem_rdata[MARK_BITS +: COORD_BITS] == r_y) begin
                        r_s_hit <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SRCH_RD;
                    end
                end
                // exchange sort: r_a holds the entry bound for position r_i
                S_SORT_RDA: begin
                    r_j     <= r_i + 1'b1;
                    r_state <= S_SORT_LDA;
                end
                S_SORT_LDA: begin
                    r_a     <= mem_rdata;
                    r_state <= S_SORT_RDB;
                end
                S_SORT_RDB: r_state <= S_SORT_CMP;
                S_SORT_CMP: begin
                    if (w_swap) begin
                        r_a <= mem_rdata;
                    end
                    if (r_j + 1'b1 >= r_count) begin
                        r_state <= S_SORT_WRA;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_SORT_RDB;
                    end
                end
                S_SORT_WRA: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= (r_i + CW'(2) < r_count) ? S_SORT_RDA : S_DONE;
                end
                // hand the result to the output register
                S_DONE: begin
                    if (w_out_free) begin
                        r_ovld   <= 1'b1;
                        r_o_hit  <= r_s_hit;
                        r_o_x    <= r_s_x;
                        r_o_y    <= r_s_y;
                        r_o_mark <= r_s_mark;
                        r_o_more <= r_s_more;
                        r_o_len  <= r_count;
                        r_o_st   <= r_s_st;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid      = r_ovld;
    assign o_rsp.hit        = r_o_hit;
    assign o_rsp.x_out      = r_o_x;
    assign o_rsp.y_out      = r_o_y;
    assign o_rsp.mark_out   = r_o_mark;
    assign o_rsp.more_after = r_o_more;
    assign o_rsp.length     = r_o_len;
    assign o_rsp.status     = r_o_st;

    // count stays within capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    // cursor always names a live entry or the top
    a_cursor_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos == '0 || w_pos_c < r_count)
        else $error("cursor beyond stack");

    // an accepted push below capacity grows the stack by one
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_req.req_type == scs_pkg::REQ_PUSH && r_count < CW'(DEPTH))
        |=> r_count == $past(r_count) + 1'b1)
        else $error("push did not grow stack");
endmodule
`default_nettype wire
